@@ rtl/dtb_pkg.sv @@
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared types and constants for the descriptor table builder.
// ----------------------------------------------------------------------------
package dtb_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned SIZE_W  = 24;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned LEN_W   = 17;   // region length, up to 64 KiB
    localparam int unsigned CMD_W   = 4;
    localparam int unsigned STAT_W  = 2;

    localparam logic [LEN_W-1:0]   REGION_SPAN   = 17'h1_0000;
    localparam logic [COUNT_W-1:0] COUNT_MASK    = 16'hFFFE;
    localparam logic [ADDR_W-1:0]  BASE_RESET    = 32'h0008_0000;

    localparam logic [CMD_W-1:0]   CMD_READ_MEM  = 4'h0;
    localparam logic [CMD_W-1:0]   CMD_WRITE_MEM = 4'h8;

    localparam logic [STAT_W-1:0]  ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0]  ST_OVERFLOW   = 2'd1;
    localparam logic [STAT_W-1:0]  ST_ZERO_SIZE  = 2'd2;

    // Operands handed to the region unit
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] bytes_left;
    } t_region_req;

    // Results of one region step
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [SIZE_W-1:0] bytes_next;
        logic [ADDR_W-1:0] addr_next;
    } t_region_res;

endpackage

@@ rtl/dtb_region_unit.sv @@
// ----------------------------------------------------------------------------
// dtb_region_unit
// Step unit: clips the next region to the 64 KiB boundary and to the
// bytes still left, then advances address and remaining byte count.
// ----------------------------------------------------------------------------
module dtb_region_unit (
    input  dtb_pkg::t_region_req i_req,
    output dtb_pkg::t_region_res o_res
);

    logic [dtb_pkg::LEN_W-1:0]  w_room;
    logic [dtb_pkg::SIZE_W-1:0] w_room_ext;
    logic [dtb_pkg::LEN_W-1:0]  w_len;

    // Bytes up to the next 64 KiB boundary (1..65536)
    assign w_room     = dtb_pkg::REGION_SPAN - {1'b0, i_req.addr[15:0]};
    assign w_room_ext = {{(dtb_pkg::SIZE_W - dtb_pkg::LEN_W){1'b0}}, w_room};
    assign w_len      = (i_req.bytes_left < w_room_ext)
                        ? i_req.bytes_left[dtb_pkg::LEN_W-1:0] : w_room;

    assign o_res.len        = w_len;
    assign o_res.bytes_next = i_req.bytes_left
                              - {{(dtb_pkg::SIZE_W - dtb_pkg::LEN_W){1'b0}}, w_len};
    assign o_res.addr_next  = i_req.addr
                              + {{(dtb_pkg::ADDR_W - dtb_pkg::LEN_W){1'b0}}, w_len};

endmodule

@@ rtl/dtb_seq.sv @@
// ----------------------------------------------------------------------------
// dtb_seq
// Request sequencer: walks one request through the region unit, one result
// per free output slot, and ends with a descriptor, overflow or error result.
// ----------------------------------------------------------------------------
module dtb_seq #(
    parameter int unsigned MAX_ENTRIES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [dtb_pkg::ADDR_W-1:0]   i_base,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [dtb_pkg::SIZE_W-1:0]   i_transfer_size,
    input  logic                         i_to_device,
    output dtb_pkg::t_region_req         o_req,
    input  dtb_pkg::t_region_res         i_res,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dtb_pkg::ADDR_W-1:0]   o_entry_address,
    output logic [dtb_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                         o_end_of_table,
    output logic [dtb_pkg::CMD_W-1:0]    o_command_byte,
    output logic [dtb_pkg::STAT_W-1:0]   o_status,
    output logic                         o_last
);

    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state                       r_state;
    logic [dtb_pkg::SIZE_W-1:0]   r_bytes;
    logic [dtb_pkg::ADDR_W-1:0]   r_addr;
    logic [CNT_W-1:0]             r_cnt;
    logic [dtb_pkg::CMD_W-1:0]    r_cmd;
    logic                         r_valid;
    logic [dtb_pkg::ADDR_W-1:0]   r_out_addr;
    logic [dtb_pkg::COUNT_W-1:0]  r_out_count;
    logic                         r_out_eot;
    logic [dtb_pkg::CMD_W-1:0]    r_out_cmd;
    logic [dtb_pkg::STAT_W-1:0]   r_out_status;
    logic                         r_out_last;

    logic w_slot_free;
    logic w_done;

    assign o_ready     = (r_state == S_IDLE);
    assign w_slot_free = !r_valid || i_ready;
    assign w_done      = (i_res.bytes_next == '0);

    assign o_req.addr       = r_addr;
    assign o_req.bytes_left = r_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (r_valid && i_ready) begin
                        r_valid <= 1'b0;
                    end
                    if (i_valid) begin
                        r_bytes <= i_transfer_size;
                        r_addr  <= i_base;
                        r_cnt   <= '0;
                        r_cmd   <= i_to_device ? dtb_pkg::CMD_READ_MEM
                                               : dtb_pkg::CMD_WRITE_MEM;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    // a busy slot here means r_valid is high and stalled
                    if (w_slot_free) begin
                        r_valid   <= 1'b1;
                        r_out_cmd <= r_cmd;
                        if (r_bytes == '0) begin
                            // zero-size request: single error result
                            r_out_addr   <= '0;
                            r_out_count  <= '0;
                            r_out_eot    <= 1'b0;
                            r_out_status <= dtb_pkg::ST_ZERO_SIZE;
                            r_out_last   <= 1'b1;
                            r_state      <= S_IDLE;
                        end else if (r_cnt >= CNT_MAX) begin
                            // table full, report where the next region starts
                            r_out_addr   <= r_addr;
                            r_out_count  <= '0;
                            r_out_eot    <= 1'b0;
                            r_out_status <= dtb_pkg::ST_OVERFLOW;
                            r_out_last   <= 1'b1;
                            r_state      <= S_IDLE;
                        end else begin
                            r_out_addr   <= r_addr;
                            r_out_count  <= i_res.len[dtb_pkg::COUNT_W-1:0]
                                            & dtb_pkg::COUNT_MASK;
                            r_out_eot    <= w_done;
                            r_out_status <= dtb_pkg::ST_OK;
                            r_out_last   <= w_done;
                            r_addr       <= i_res.addr_next;
                            r_bytes      <= i_res.bytes_next;
                            r_cnt        <= r_cnt + CNT_W'(1);
                            if (w_done) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_entry_address = r_out_addr;
    assign o_entry_count   = r_out_count;
    assign o_end_of_table  = r_out_eot;
    assign o_command_byte  = r_out_cmd;
    assign o_status        = r_out_status;
    assign o_last          = r_out_last;

endmodule

@@ rtl/dma_descriptor_table_builder.sv @@
// ----------------------------------------------------------------------------
// dma_descriptor_table_builder
// Builds a bus-master descriptor table for one transfer request.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): one transaction carries a request, a byte
// size and a direction. Output channel (o_valid/i_ready): one transaction per
// result: up to MAX_ENTRIES descriptors, each stopping at a 64 KiB boundary,
// the last one flagged with o_end_of_table and o_last. A request needing more
// descriptors ends with an overflow result; a zero size gives one error result.
// Config channel (i_cfg_valid/o_cfg_ready): writes the buffer base address,
// always ready; write it only while no request is in flight.
// The request is loaded into the sequencer state S_RUN, and the first result
// is then registered once the output slot is free. Throughput: one result per
// cycle from the region step unit while the output slot is free; o_ready stays
// low until the final result has been loaded.
// A stalled receiver holds the output register and pauses the sequencer.
// Reset: sequencer idle, output empty, base address back to 0x0008_0000.
// ----------------------------------------------------------------------------
module dma_descriptor_table_builder #(
    parameter int unsigned MAX_ENTRIES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [dtb_pkg::ADDR_W-1:0]   i_buffer_base,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [dtb_pkg::SIZE_W-1:0]   i_transfer_size,
    input  logic                         i_to_device,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dtb_pkg::ADDR_W-1:0]   o_entry_address,
    output logic [dtb_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                         o_end_of_table,
    output logic [dtb_pkg::CMD_W-1:0]    o_command_byte,
    output logic [dtb_pkg::STAT_W-1:0]   o_status,
    output logic                         o_last
);

    logic [dtb_pkg::ADDR_W-1:0] r_base;
    dtb_pkg::t_region_req       w_req;
    dtb_pkg::t_region_res       w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= dtb_pkg::BASE_RESET;
        end else if (i_cfg_valid) begin
            r_base <= i_buffer_base;
        end
    end

    dtb_region_unit u_region (
        .i_req (w_req),
        .o_res (w_res)
    );

    dtb_seq #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_base          (r_base),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_transfer_size (i_transfer_size),
        .i_to_device     (i_to_device),
        .o_req           (w_req),
        .i_res           (w_res),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_entry_address (o_entry_address),
        .o_entry_count   (o_entry_count),
        .o_end_of_table  (o_end_of_table),
        .o_command_byte  (o_command_byte),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule

@@ rtl/dtb_checker.sv @@
// ----------------------------------------------------------------------------
// dtb_checker
// Port-level checks for the descriptor table builder, bound to the top level.
// ----------------------------------------------------------------------------
module dtb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [dtb_pkg::ADDR_W-1:0]   o_entry_address,
    input logic [dtb_pkg::COUNT_W-1:0]  o_entry_count,
    input logic                         o_end_of_table,
    input logic [dtb_pkg::STAT_W-1:0]   o_status,
    input logic                         o_last
);

    // overflow and error results always close the request
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != dtb_pkg::ST_OK) |-> o_last)
        else $error("error result without last");

    // end of table only on the final, good descriptor
    a_eot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_table) |-> (o_last && o_status == dtb_pkg::ST_OK))
        else $error("end_of_table on a non-final result");

    // a taken request blocks the next one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while busy");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_entry_address)
                                   && $stable(o_entry_count) && $stable(o_status)))
        else $error("result changed under stall");

endmodule

bind dma_descriptor_table_builder dtb_checker u_dtb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_entry_address (o_entry_address),
    .o_entry_count   (o_entry_count),
    .o_end_of_table  (o_end_of_table),
    .o_status        (o_status),
    .o_last          (o_last)
);
